// ===== hw/rtl/qct_pkg.sv =====
// Package for the quoted command tokenizer: codes, character constants,
// the result word type and the character classification functions.
// No dependencies.
`default_nettype none

package qct_pkg;

    // op codes on the input tuser
    localparam logic OP_CHAR = 1'b0;
    localparam logic OP_END  = 1'b1;

    // open quote codes
    typedef logic [1:0] t_quote;
    localparam t_quote QUOTE_NONE   = 2'd0;
    localparam t_quote QUOTE_DOUBLE = 2'd1;
    localparam t_quote QUOTE_SINGLE = 2'd2;

    localparam logic [7:0] CH_NUL     = 8'h00;
    localparam logic [7:0] CH_WS_LO   = 8'h09;
    localparam logic [7:0] CH_WS_HI   = 8'h0D;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_DQUOTE  = 8'h22;
    localparam logic [7:0] CH_SQUOTE  = 8'h27;

    // result queue
    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_last;
    } t_result;

    function automatic logic is_space(input logic [7:0] c);
        is_space = ((c >= CH_WS_LO) && (c <= CH_WS_HI)) || (c == CH_SPACE);
    endfunction

    function automatic t_quote quote_code(input logic [7:0] c);
        if (c == CH_DQUOTE) begin
            quote_code = QUOTE_DOUBLE;
        end else if (c == CH_SQUOTE) begin
            quote_code = QUOTE_SINGLE;
        end else begin
            quote_code = QUOTE_NONE;
        end
    endfunction

    function automatic logic [7:0] quote_byte(input t_quote q);
        quote_byte = (q == QUOTE_SINGLE) ? CH_SQUOTE : CH_DQUOTE;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/quoted_command_tokenizer.sv =====
// Quoted command tokenizer top level: classifies each input word and
// queues zero, one or two result words. Depends on qct_pkg.
`default_nettype none

// Takes one command character (tuser = 0) or end-of-command (tuser = 1) per
// word and emits the token stream: zero bytes separate tokens, quoted spans
// pass through, and end-of-command yields a zero byte with tlast set. Each
// input word is classified in the cycle it is accepted and its results are
// written into a four-entry output queue; when nothing is queued ahead, the
// first is offered the cycle after acceptance. The input side takes a word
// every cycle while the queue has room for two results. The output delivers
// one word per cycle, so with the output ready the sustained input rate is one
// word per cycle: an empty quote pair yields two results, but its opening
// quote yields none, so the pair never stalls the input. Only output
// backpressure that fills the queue past two entries holds the input.
module quoted_command_tokenizer
    import qct_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_s_tvalid,
    output logic            o_s_tready,
    input  wire logic [7:0] i_s_tdata,   // [7:0] ch
    input  wire logic       i_s_tuser,   // [0] op
    output logic            o_m_tvalid,
    input  wire logic       i_m_tready,
    output logic [7:0]      o_m_tdata,   // [7:0] out_byte
    output logic            o_m_tlast
);

    t_quote             r_open_quote, n_open_quote;
    logic               r_quote_pending, n_quote_pending;
    logic               r_after_sep, n_after_sep;
    t_result            r_fifo [FIFO_DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0]   r_count, n_count;

    logic               s_accept, m_accept;
    logic [7:0]         c;
    t_quote             q;
    t_result            res0, res1;
    logic [1:0]         res_cnt;

    assign o_s_tready = i_rst_n && (r_count <= CNT_W'(FIFO_DEPTH - 2));
    assign o_m_tvalid = i_rst_n && (r_count != '0);
    assign o_m_tdata  = r_fifo[r_rd_ptr].out_byte;
    assign o_m_tlast  = r_fifo[r_rd_ptr].out_last;

    assign s_accept = i_s_tvalid && o_s_tready;
    assign m_accept = o_m_tvalid && i_m_tready;

    // newline counts as space everywhere
    assign c = (i_s_tdata == CH_NEWLINE) ? CH_SPACE : i_s_tdata;
    assign q = quote_code(c);

    always_comb begin
        n_open_quote    = r_open_quote;
        n_quote_pending = r_quote_pending;
        n_after_sep     = r_after_sep;
        res0            = '{out_byte: c, out_last: 1'b0};
        res1            = '{out_byte: c, out_last: 1'b0};
        res_cnt         = 2'd0;
        if (i_s_tuser == OP_END) begin
            res0            = '{out_byte: CH_NUL, out_last: 1'b1};
            res_cnt         = 2'd1;
            n_open_quote    = QUOTE_NONE;
            n_quote_pending = 1'b0;
            n_after_sep     = 1'b0;
        end else if (r_quote_pending) begin
            n_quote_pending = 1'b0;
            if (q == r_open_quote) begin
                // empty pair: keep both quotes
                res0.out_byte = quote_byte(r_open_quote);
                res_cnt       = 2'd2;
                n_open_quote  = QUOTE_NONE;
                n_after_sep   = 1'b0;
            end else begin
                res_cnt = 2'd1;
            end
        end else if (r_open_quote != QUOTE_NONE) begin
            res_cnt = 2'd1;
            if (q == r_open_quote) begin
                res0.out_byte = CH_NUL;
                n_open_quote  = QUOTE_NONE;
                n_after_sep   = 1'b1;
            end
        end else if (q != QUOTE_NONE) begin
            n_open_quote    = q;
            n_quote_pending = 1'b1;
            n_after_sep     = 1'b0;
        end else if (is_space(c)) begin
            if (!r_after_sep) begin
                res0.out_byte = CH_NUL;
                res_cnt       = 2'd1;
                n_after_sep   = 1'b1;
            end
        end else begin
            res_cnt     = 2'd1;
            n_after_sep = 1'b0;
        end
    end

    always_comb begin
        n_count = r_count;
        if (s_accept) begin
            n_count = n_count + CNT_W'(res_cnt);
        end
        if (m_accept) begin
            n_count = n_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open_quote    <= QUOTE_NONE;
            r_quote_pending <= 1'b0;
            r_after_sep     <= 1'b0;
            r_wr_ptr        <= '0;
            r_rd_ptr        <= '0;
            r_count         <= '0;
        end else begin
            r_count <= n_count;
            if (s_accept) begin
                r_open_quote    <= n_open_quote;
                r_quote_pending <= n_quote_pending;
                r_after_sep     <= n_after_sep;
                r_wr_ptr        <= r_wr_ptr + PTR_W'(res_cnt);
            end
            if (m_accept) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
        end
    end

    // payload queue, no reset
    always_ff @(posedge i_clk) begin
        if (s_accept && (res_cnt != 2'd0)) begin
            r_fifo[r_wr_ptr] <= res0;
        end
        if (s_accept && (res_cnt == 2'd2)) begin
            r_fifo[r_wr_ptr + PTR_W'(1)] <= res1;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/qct_checker.sv =====
// Port-level checks for the quoted command tokenizer, bound to the top level.
// Depends on qct_pkg and quoted_command_tokenizer.
`default_nettype none

module qct_checker
    import qct_pkg::*;
(
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_s_tvalid,
    input wire logic       i_s_tready,
    input wire logic       i_m_tvalid,
    input wire logic       i_m_tready,
    input wire logic [7:0] i_m_tdata,
    input wire logic       i_m_tlast
);

    // a held output word stays offered
    a_m_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && !i_m_tready |=> i_m_tvalid)
        else $error("output word dropped while stalled");

    // the end-of-command word is always a zero terminator
    a_last_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && i_m_tlast |-> i_m_tdata == CH_NUL)
        else $error("last word is not a zero byte");

    // input backpressure only comes from a queue holding results
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && !i_s_tready |-> i_m_tvalid)
        else $error("input stalled with empty output");

    // reset empties the result queue
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_m_tvalid)
        else $error("output valid right after reset");

endmodule

bind quoted_command_tokenizer qct_checker u_qct_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .i_s_tready (o_s_tready),
    .i_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .i_m_tdata  (o_m_tdata),
    .i_m_tlast  (o_m_tlast)
);

`default_nettype wire
